### rtl/core/csched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cooperative scheduler package
// Shared types and constants for the slot table, the slot update unit and
// the scan sequencer.
// ----------------------------------------------------------------------------
package csched_pkg;

   localparam int TAG_W      = 8;
   localparam int TIME_W     = 16;
   localparam int PEND_W     = 8;
   localparam int SLOT_OUT_W = 7;
   localparam int IDX_W      = 6;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ADDED   = 3'd0,
      KIND_FULL    = 3'd1,
      KIND_DELETED = 3'd2,
      KIND_DEL_ERR = 3'd3,
      KIND_RUN     = 3'd4
   } kind_type;

   // One slot as held in the table memory; the valid mark lives in flops.
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic [PEND_W-1:0] pending;
   } entry_type;

   // Sequencer to update unit.
   typedef struct packed {
      logic dispatch;
      logic valid;
   } slot_ctl_type;

   // Update unit to sequencer.
   typedef struct packed {
      logic      write;
      logic      free;
      logic      emit;
      entry_type entry;
   } slot_upd_type;

endpackage

### rtl/core/cooperative_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cooperative task scheduler
// Time-triggered task slot table with tick, add, delete and dispatch words.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+---------------------------------
//  req     | in        | req_tvalid/tready  | tuser: opcode; tdata: tag, start
//          |           |                    | delay, repeat period, slot index
//  rsp     | out       | rsp_tvalid/tready  | tuser: result kind; tdata: slot,
//          |           |                    | run tag; tlast: final result
//
// A tick or dispatch word walks the whole table, reading one slot from the
// table memory and passing it through the single slot update unit per cycle
// unless a stalled result holds the pass. An add word walks the slots up to
// the first free one. The block accepts no new word until the current one
// is finished. Reset clears the valid marks at once, so no clearing pass is
// needed. A stalled result port halts a dispatch pass until the result
// register drains; a new word may be accepted while the last result waits.
//
module cooperative_task_scheduler #(
   parameter int TASK_SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request word.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] task_tag, [23:8] start_delay, [39:24] repeat_period,
   // [45:40] slot_index, [47:46] zero
   input  logic [csched_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] opcode
   input  logic [1:0]                         req_tuser,
   // Response word.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] slot, [14:7] run_tag, [15] zero
   output logic [csched_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] result_kind
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import csched_pkg::*;

   // The slot counter needs at least one bit even for a single slot.
   localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rd_data;
   slot_ctl_type      ctl;
   slot_upd_type      upd;

   // Table storage for tag, delay, period and pending count.
   csched_slot_mem #(
      .DEPTH  (TASK_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The one update unit shared by every slot of a pass.
   csched_slot_alu u_alu (
      .ctl (ctl),
      .cur (rd_data),
      .upd (upd)
   );

   // Sequencer, valid marks and the result register.
   csched_seq #(
      .TASK_SLOTS (TASK_SLOTS),
      .SLOT_W     (SLOT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .ctl        (ctl),
      .upd        (upd)
   );

endmodule

### rtl/core/csched_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csched_slot_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  csched_pkg::entry_type wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output csched_pkg::entry_type rd_data
);
   import csched_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/csched_slot_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot update unit
// Computes the new contents of one slot for a tick or a dispatch pass.
// ----------------------------------------------------------------------------
module csched_slot_alu (
   input  csched_pkg::slot_ctl_type ctl,
   input  csched_pkg::entry_type    cur,
   output csched_pkg::slot_upd_type upd
);
   import csched_pkg::*;

   always_comb begin
      upd       = '0;
      upd.entry = cur;
      if (ctl.valid) begin
         if (ctl.dispatch) begin
            if (cur.pending != '0) begin
               upd.emit          = 1'b1;
               upd.entry.pending = cur.pending - PEND_W'(1);
               // A one-shot task leaves the table once it has run.
               if (cur.period == '0) begin
                  upd.free = 1'b1;
               end else begin
                  upd.write = 1'b1;
               end
            end
         end else begin
            upd.write = 1'b1;
            if (cur.delay == '0) begin
               if (cur.pending != PEND_MAX) begin
                  upd.entry.pending = cur.pending + PEND_W'(1);
               end
               if (cur.period != '0) begin
                  upd.entry.delay = cur.period;
               end
            end else begin
               upd.entry.delay = cur.delay - TIME_W'(1);
            end
         end
      end
   end

endmodule

### rtl/core/csched_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Walks the slots one per cycle unless a stalled result holds the scan,
// keeps the valid marks and drives the result register.
// ----------------------------------------------------------------------------
module csched_seq #(
   parameter int TASK_SLOTS = 16,
   parameter int SLOT_W     = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [csched_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [csched_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [2:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                wr_en,
   output logic [SLOT_W-1:0]                   wr_addr,
   output csched_pkg::entry_type               wr_data,
   output logic                                rd_en,
   output logic [SLOT_W-1:0]                   rd_addr,
   input  csched_pkg::entry_type               rd_data,
   output csched_pkg::slot_ctl_type            ctl,
   input  csched_pkg::slot_upd_type            upd
);
   import csched_pkg::*;

   localparam logic [SLOT_W-1:0]     LAST_SLOT  = SLOT_W'(TASK_SLOTS - 1);
   localparam logic [SLOT_OUT_W-1:0] SLOT_COUNT = SLOT_OUT_W'(TASK_SLOTS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_FIND  = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       cnt_ff, cnt_in;
   logic [TASK_SLOTS-1:0]   valid_ff, valid_in;
   op_type                  op_ff, op_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic [TIME_W-1:0]       dly_ff, dly_in;
   logic [TIME_W-1:0]       per_ff, per_in;
   logic                    held_vld_ff, held_vld_in;
   logic [SLOT_W-1:0]       held_slot_ff, held_slot_in;
   logic [TAG_W-1:0]        held_tag_ff, held_tag_in;
   kind_type                reply_kind_ff, reply_kind_in;
   logic [SLOT_OUT_W-1:0]   reply_slot_ff, reply_slot_in;
   logic                    out_vld_ff, out_vld_in;
   kind_type                out_kind_ff, out_kind_in;
   logic [SLOT_OUT_W-1:0]   out_slot_ff, out_slot_in;
   logic [TAG_W-1:0]        out_tag_ff, out_tag_in;
   logic                    out_last_ff, out_last_in;

   logic                    out_free;
   logic                    stall;
   logic [IDX_W-1:0]        req_idx;
   logic                    idx_in_range;

   assign out_free     = !out_vld_ff || rsp_tready;
   assign stall        = upd.emit && held_vld_ff && !out_free;
   assign req_idx      = req_tdata[45:40];
   assign idx_in_range = SLOT_OUT_W'(req_idx) < SLOT_COUNT;

   assign ctl.dispatch = (op_ff == OP_DISPATCH);
   assign ctl.valid    = valid_ff[cnt_ff];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      dly_in        = dly_ff;
      per_in        = per_ff;
      held_vld_in   = held_vld_ff;
      held_slot_in  = held_slot_ff;
      held_tag_in   = held_tag_ff;
      reply_kind_in = reply_kind_ff;
      reply_slot_in = reply_slot_ff;
      out_vld_in    = out_vld_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff;
      wr_data       = upd.entry;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = op_type'(req_tuser);
               tag_in = req_tdata[7:0];
               dly_in = req_tdata[23:8];
               per_in = req_tdata[39:24];
               cnt_in = '0;
               unique case (op_type'(req_tuser))
                  OP_TICK, OP_DISPATCH: begin
                     rd_en    = 1'b1;
                     state_in = ST_SCAN;
                  end
                  OP_ADD: begin
                     state_in = ST_FIND;
                  end
                  OP_DELETE: begin
                     reply_slot_in = SLOT_OUT_W'(req_idx);
                     reply_kind_in = KIND_DEL_ERR;
                     if (idx_in_range && valid_ff[req_idx[SLOT_W-1:0]]) begin
                        valid_in[req_idx[SLOT_W-1:0]] = 1'b0;
                        reply_kind_in                 = KIND_DELETED;
                     end
                     state_in = ST_REPLY;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               wr_en = upd.write;
               if (upd.free) begin
                  valid_in[cnt_ff] = 1'b0;
               end
               if (upd.emit) begin
                  // The previous run leaves only once a later one is known,
                  // so the final run of the pass can carry the last mark.
                  if (held_vld_ff) begin
                     out_vld_in  = 1'b1;
                     out_kind_in = KIND_RUN;
                     out_slot_in = SLOT_OUT_W'(held_slot_ff);
                     out_tag_in  = held_tag_ff;
                     out_last_in = 1'b0;
                  end
                  held_vld_in  = 1'b1;
                  held_slot_in = cnt_ff;
                  held_tag_in  = rd_data.tag;
               end
               if (cnt_ff == LAST_SLOT) begin
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in  = cnt_ff + SLOT_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = cnt_ff + SLOT_W'(1);
               end
            end
         end
         ST_FIND: begin
            if (!valid_ff[cnt_ff]) begin
               wr_en            = 1'b1;
               wr_data.tag      = tag_ff;
               wr_data.delay    = dly_ff;
               wr_data.period   = per_ff;
               wr_data.pending  = '0;
               valid_in[cnt_ff] = 1'b1;
               reply_kind_in    = KIND_ADDED;
               reply_slot_in    = SLOT_OUT_W'(cnt_ff);
               state_in         = ST_REPLY;
            end else if (cnt_ff == LAST_SLOT) begin
               reply_kind_in = KIND_FULL;
               reply_slot_in = SLOT_COUNT;
               state_in      = ST_REPLY;
            end else begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         ST_FLUSH: begin
            if (!held_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_vld_in  = 1'b1;
               out_kind_in = KIND_RUN;
               out_slot_in = SLOT_OUT_W'(held_slot_ff);
               out_tag_in  = held_tag_ff;
               out_last_in = 1'b1;
               held_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_kind_in = reply_kind_ff;
               out_slot_in = reply_slot_ff;
               out_tag_in  = '0;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         valid_ff    <= '0;
         held_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         op_ff       <= OP_TICK;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         valid_ff    <= valid_in;
         held_vld_ff <= held_vld_in;
         out_vld_ff  <= out_vld_in;
         op_ff       <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff        <= tag_in;
      dly_ff        <= dly_in;
      per_ff        <= per_in;
      held_slot_ff  <= held_slot_in;
      held_tag_ff   <= held_tag_in;
      reply_kind_ff <= reply_kind_in;
      reply_slot_ff <= reply_slot_in;
      out_kind_ff   <= out_kind_in;
      out_slot_ff   <= out_slot_in;
      out_tag_ff    <= out_tag_in;
      out_last_ff   <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {1'b0, out_tag_ff, out_slot_ff};
   assign rsp_tlast  = out_last_ff;

   // No run result may be held back once the sequencer is idle again.
   a_held_empty_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !held_vld_ff)
      else $error("run result left behind after a pass");

   // The free-slot search only ever fills a slot that is free.
   a_add_free_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND && wr_en |-> !valid_ff[cnt_ff])
      else $error("add overwrote a slot in use");

   // A stalled run result keeps the scan position and the held result.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && stall |=> state_ff == ST_SCAN && $stable(cnt_ff)
         && held_vld_ff)
      else $error("scan moved on while a result was stalled");

   // Run results come only from a tick or dispatch pass.
   a_run_from_pass: assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff ##1 out_vld_ff && out_kind_ff == KIND_RUN
         |-> $past(state_ff) == ST_SCAN || $past(state_ff) == ST_FLUSH)
      else $error("run result outside a dispatch pass");

endmodule

### sim/tb_cooperative_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cooperative task scheduler testbench
// Drives tick, add, delete and dispatch words into the scheduler and keeps a
// mirror of the slot table. Every result word that leaves the block is
// compared field by field with the oldest result the mirror says is due.
// The run covers directed corner cases and random traffic under several
// sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_cooperative_task_scheduler;
   import csched_pkg::*;

   localparam int TASK_SLOTS = 16;
   // Settle time after the last due result, long enough for a full tick or dispatch pass.
   localparam int SETTLE_CYCLES = TASK_SLOTS + 8;

   // One expected result word.
   typedef struct {
      kind_type         kind;
      logic [6:0]       slot;
      logic [TAG_W-1:0] run_tag;
      logic             last;
   } result_word;

   // Mirror of the slot table. It applies each accepted request word and
   // queues the result words that the word must produce. It then matches
   // them against what the block sends.
   class sched_table_mirror;
      logic              used[TASK_SLOTS];
      logic [TAG_W-1:0]  tag[TASK_SLOTS];
      logic [TIME_W-1:0] delay[TASK_SLOTS];
      logic [TIME_W-1:0] period[TASK_SLOTS];
      logic [PEND_W-1:0] pending[TASK_SLOTS];
      result_word        due_results[$];
      int                errors;

      function new();
         errors = 0;
         for (int s = 0; s < TASK_SLOTS; s++) begin
            free_slot(s);
         end
      endfunction

      function void free_slot(int s);
         used[s]    = 1'b0;
         tag[s]     = '0;
         delay[s]   = '0;
         period[s]  = '0;
         pending[s] = '0;
      endfunction

      function void queue_result(kind_type kind, int s, logic [TAG_W-1:0] rtag);
         result_word r;
         r.kind    = kind;
         r.slot    = 7'(s);
         r.run_tag = rtag;
         r.last    = 1'b0;
         due_results.push_back(r);
      endfunction

      function void apply_word(op_type op, logic [TAG_W-1:0] wtag,
                               logic [TIME_W-1:0] wdelay, logic [TIME_W-1:0] wperiod,
                               logic [IDX_W-1:0] widx);
         int s;
         int runs;
         runs = 0;
         case (op)
            OP_TICK: begin
               // A slot that is due gains a pending run and, if periodic,
               // reloads its delay. Ticks give no result words.
               for (s = 0; s < TASK_SLOTS; s++) begin
                  if (used[s]) begin
                     if (delay[s] == '0) begin
                        if (pending[s] != PEND_MAX) begin
                           pending[s]++;
                        end
                        if (period[s] != '0) begin
                           delay[s] = period[s];
                        end
                     end else begin
                        delay[s]--;
                     end
                  end
               end
            end
            OP_ADD: begin
               for (s = 0; s < TASK_SLOTS; s++) begin
                  if (!used[s]) begin
                     break;
                  end
               end
               if (s >= TASK_SLOTS) begin
                  queue_result(KIND_FULL, TASK_SLOTS, '0);
               end else begin
                  used[s]    = 1'b1;
                  tag[s]     = wtag;
                  delay[s]   = wdelay;
                  period[s]  = wperiod;
                  pending[s] = '0;
                  queue_result(KIND_ADDED, s, '0);
               end
            end
            OP_DELETE: begin
               if (widx >= TASK_SLOTS) begin
                  queue_result(KIND_DEL_ERR, widx, '0);
               end else if (used[widx]) begin
                  free_slot(widx);
                  queue_result(KIND_DELETED, widx, '0);
               end else begin
                  free_slot(widx);
                  queue_result(KIND_DEL_ERR, widx, '0);
               end
            end
            default: begin
               // Dispatch: one run word per slot with pending runs, lowest
               // slot first. One-shot slots are released once they run.
               for (s = 0; s < TASK_SLOTS; s++) begin
                  if (used[s] && pending[s] != '0) begin
                     queue_result(KIND_RUN, s, tag[s]);
                     runs++;
                     pending[s]--;
                     if (period[s] == '0) begin
                        free_slot(s);
                     end
                  end
               end
            end
         endcase
         // The final word caused by add, delete or a non-empty dispatch
         // carries tlast.
         if (op != OP_TICK && (op != OP_DISPATCH || runs > 0)) begin
            due_results[due_results.size()-1].last = 1'b1;
         end
      endfunction

      function void take_result(kind_type kind, logic [6:0] slot,
                                logic [TAG_W-1:0] rtag, logic last);
         result_word exp;
         if (due_results.size() == 0) begin
            errors++;
            $error("result word with nothing due: kind %0d slot %0d run_tag %0d last %0d",
                   kind, slot, rtag, last);
            return;
         end
         exp = due_results.pop_front();
         if (kind !== exp.kind) begin
            errors++;
            $error("result_kind: expected %0d, got %0d", exp.kind, kind);
         end
         if (slot !== exp.slot) begin
            errors++;
            $error("slot: expected %0d, got %0d", exp.slot, slot);
         end
         if (rtag !== exp.run_tag) begin
            errors++;
            $error("run_tag: expected %0d, got %0d", exp.run_tag, rtag);
         end
         if (last !== exp.last) begin
            errors++;
            $error("last: expected %0d, got %0d", exp.last, last);
         end
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [7:0] task_tag, [23:8] start_delay, [39:24] repeat_period,
   // [45:40] slot_index, [47:46] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [1:0] opcode
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [6:0] slot, [14:7] run_tag, [15] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [2:0] result_kind
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;

   // Idling mix: chance in percent that the sender inserts an idle cycle
   // before a word, and that the receiver holds tready low in a cycle.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   sched_table_mirror sched_mirror;

   cooperative_task_scheduler #(
      .TASK_SLOTS(TASK_SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // 2 ns clock period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side. Values read here are the ones that held just before the
   // edge, because the block and this process both update with
   // nonblocking assignments. A word counts when tvalid and tready were
   // both high.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sched_mirror.take_result(kind_type'(rsp_tuser), rsp_tdata[6:0],
                                  rsp_tdata[14:7], rsp_tlast);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Send one request word and hand it to the mirror once it is taken.
   // Idle cycles, if any, come before the word so that gaps fall between
   // words. A word that follows directly keeps tvalid high.
   task automatic send_word(input op_type op, input logic [TAG_W-1:0] wtag,
                            input logic [TIME_W-1:0] wdelay,
                            input logic [TIME_W-1:0] wperiod,
                            input logic [IDX_W-1:0] widx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, widx, wperiod, wdelay, wtag};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sched_mirror.apply_word(op, wtag, wdelay, wperiod, widx);
   endtask

   // Hold off the sender until every due result has arrived. Then let a
   // full table pass go by so a trailing tick is finished too.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sched_mirror.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random word. Most tasks get short delays and periods so that they come
   // due, get dispatched and free their slots again. Occasional full-range
   // values exercise the wide timer bits. Fields an opcode does not use are
   // random as well.
   task automatic send_random_word();
      int                pick;
      op_type            op;
      logic [TIME_W-1:0] wdelay;
      logic [TIME_W-1:0] wperiod;
      logic [IDX_W-1:0]  widx;
      pick = $urandom_range(99);
      if (pick < 35) begin
         op = OP_TICK;
      end else if (pick < 60) begin
         op = OP_ADD;
      end else if (pick < 75) begin
         op = OP_DELETE;
      end else begin
         op = OP_DISPATCH;
      end
      wdelay = ($urandom_range(15) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(4));
      pick = $urandom_range(9);
      if (pick < 3) begin
         wperiod = '0;
      end else if (pick < 9) begin
         wperiod = TIME_W'($urandom_range(4, 1));
      end else begin
         wperiod = TIME_W'($urandom);
      end
      // Mostly real slots; now and then an index beyond the table.
      widx = ($urandom_range(4) == 0) ? IDX_W'($urandom_range(63))
                                      : IDX_W'($urandom_range(TASK_SLOTS-1));
      send_word(op, TAG_W'($urandom_range(255)), wdelay, wperiod, widx);
   endtask

   initial begin : stimulus
      int phase_stall[4][2];
      sched_mirror = new();
      phase_stall = '{'{0, 0}, '{66, 0}, '{0, 66}, '{30, 30}};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corner cases, no idling. An empty table dispatches
      // nothing.
      send_word(OP_DISPATCH, 8'h00, 16'hFFFF, 16'hFFFF, 6'h3F);
      // Deleting an empty slot, and indexes beyond the table.
      send_word(OP_DELETE, 8'hFF, 16'h0000, 16'h0000, 6'd0);
      send_word(OP_DELETE, 8'h00, 16'h0000, 16'h0000, 6'd63);
      send_word(OP_DELETE, 8'h5A, 16'h1234, 16'h8001, 6'(TASK_SLOTS));
      // One-shot task with zero delay. It gains a run on every tick, yet
      // runs once and frees its slot.
      send_word(OP_ADD, 8'hFF, 16'h0000, 16'h0000, 6'h2A);
      send_word(OP_TICK, 8'h33, 16'hFFFF, 16'h0000, 6'h00);
      send_word(OP_TICK, 8'hCC, 16'h0000, 16'hFFFF, 6'h3F);
      send_word(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 6'h00);
      // Fill the whole table, then overflow it. Slot 14 is one-shot and
      // slot 15 has the longest period.
      for (int i = 0; i < TASK_SLOTS; i++) begin
         send_word(OP_ADD, TAG_W'(i * 17), 16'h0000,
                   (i == 14) ? 16'h0000 : ((i == 15) ? 16'hFFFF : 16'h0001),
                   IDX_W'(i));
      end
      send_word(OP_ADD, 8'hA5, 16'h0001, 16'h0001, 6'h00);
      // Every slot comes due at once: a dispatch with one run per slot.
      send_word(OP_TICK, 8'h00, 16'h0000, 16'h0000, 6'h00);
      send_word(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 6'h00);
      send_word(OP_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 6'h00);

      // Clear the table so that random traffic starts from empty.
      for (int i = 0; i < TASK_SLOTS; i++) begin
         send_word(OP_DELETE, 8'h00, 16'h0000, 16'h0000, IDX_W'(i));
      end
      wait_quiet();

      // Random traffic in four idling mixes. Between mixes the sender waits
      // for every due result.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = phase_stall[p][0];
         recv_stall_pct = phase_stall[p][1];
         repeat (40) send_random_word();
         wait_quiet();
      end

      if (sched_mirror.errors == 0 && sched_mirror.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
rtl/core/csched_pkg.sv
rtl/core/csched_slot_mem.sv
rtl/core/csched_slot_alu.sv
rtl/core/csched_seq.sv
rtl/core/cooperative_task_scheduler.sv
sim/tb_cooperative_task_scheduler.sv
